// ----- hw/rtl/rcr_pkg.sv -----
// Shared types, codes and constants of the rectangle canvas rasteriser.
`default_nettype none
package rcr_pkg;

    localparam int MAX_SIDE_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;

    localparam int CMD_W    = 2;
    localparam int COORD_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SIDE_CFG_W = 9;
    localparam int DIFF_W     = 34;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [BYTE_W-1:0] SHAPE_OUTLINE = 8'h72;
    localparam logic [BYTE_W-1:0] SHAPE_FILLED  = 8'h52;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 2'd2;

    typedef logic signed [DIFF_W-1:0] t_diff;

endpackage
`default_nettype wire

// ----- hw/rtl/rcr_if.sv -----
// Command and result channel interfaces of the rectangle canvas rasteriser.
`default_nettype none
interface rcr_in_if;
    import rcr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic signed [COORD_W-1:0] rect_width;
    logic signed [COORD_W-1:0] rect_height;
    logic [BYTE_W-1:0]         shape_type;
    logic [BYTE_W-1:0]         color;
    logic [BYTE_W-1:0]         read_row;
    logic [BYTE_W-1:0]         read_col;

    modport source (output valid, cmd, rect_x, rect_y, rect_width, rect_height,
                    shape_type, color, read_row, read_col, input ready);
    modport sink (input valid, cmd, rect_x, rect_y, rect_width, rect_height,
                  shape_type, color, read_row, read_col, output ready);
endinterface

interface rcr_out_if;
    import rcr_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   pixel;

    modport source (output valid, status, pixel, input ready);
    modport sink (input valid, status, pixel, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rcr_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none
module rcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/rectangle_canvas_rasterizer.sv -----
// Top level of the rectangle canvas rasteriser: sequencer, scan unit and canvas RAM.
//
// Commands arrive on the i_in channel and each gives exactly one result on o_out
// (status and pixel). A transfer on either channel happens when valid and ready
// are both high. Configuration registers are written through i_cfg_we, i_cfg_idx
// and i_cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it. A clear or an accepted draw scans the active
// canvas one pixel per cycle; the single RAM write port and the one shared edge
// compare unit set that rate. A read takes its pixel from the registered RAM
// read; a rejected draw or an unused command goes straight to the result step.
// The block accepts a new command only when its sequencer is idle, which it
// returns to as soon as the result sits in the output register; a stalled
// receiver therefore holds up at most the next command at its final step.
// Reset clears the error flag, the scan position and the output valid, and sets
// the canvas width and height to one and the background to zero. The canvas RAM
// is not cleared: a pixel must be written by a clear or a draw before it is read.
`default_nettype none
module rectangle_canvas_rasterizer #(
    parameter int MAX_SIDE  = rcr_pkg::MAX_SIDE_DEF,
    parameter int FRAC_BITS = rcr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rcr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rcr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rcr_in_if.sink                               i_in,
    rcr_out_if.source                            o_out
);
    import rcr_pkg::*;

    localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int SW = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;
    localparam int RW = (IDX_W > BYTE_W) ? IDX_W : BYTE_W;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH = 1 << ADDR_W;
    localparam t_diff ONE = t_diff'(1) <<< FRAC_BITS;
    localparam logic [SW-1:0] MAX_SIDE_V = SW'(MAX_SIDE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    logic [SIDE_CFG_W-1:0] r_cfg_w;
    logic [SIDE_CFG_W-1:0] r_cfg_h;
    logic [BYTE_W-1:0]     r_bg;
    logic                  r_err;
    logic                  r_clear;
    logic                  r_outline;
    logic [BYTE_W-1:0]     r_color;
    logic [IDX_W-1:0]      r_row;
    logic [IDX_W-1:0]      r_col;
    t_diff r_dx;
    t_diff r_dy;
    t_diff r_dx0;
    t_diff r_rw;
    t_diff r_rh;
    t_diff r_rw_m1;
    t_diff r_rh_m1;
    logic [STATUS_W-1:0]   r_res_status;
    logic [BYTE_W-1:0]     r_res_pixel;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [BYTE_W-1:0]     r_out_pixel;

    logic [SW-1:0]     w_side;
    logic [SW-1:0]     h_side;
    logic [RW-1:0]     rd_row;
    logic [RW-1:0]     rd_col;
    logic              rd_outside;
    logic              draw_bad;
    logic              in_x, in_y, bd_x, bd_y, hit;
    logic              last_col, last_row;
    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= SIDE_CFG_W'(1);
            r_cfg_h <= SIDE_CFG_W'(1);
            r_bg    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CANVAS_WIDTH:  r_cfg_w <= i_cfg_data[SIDE_CFG_W-1:0];
                REG_CANVAS_HEIGHT: r_cfg_h <= i_cfg_data[SIDE_CFG_W-1:0];
                REG_BACKGROUND:    r_bg    <= i_cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w_side = SW'(1);
        end else if (SW'(r_cfg_w) > MAX_SIDE_V) begin
            w_side = MAX_SIDE_V;
        end else begin
            w_side = SW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_side = SW'(1);
        end else if (SW'(r_cfg_h) > MAX_SIDE_V) begin
            h_side = MAX_SIDE_V;
        end else begin
            h_side = SW'(r_cfg_h);
        end
    end

    assign rd_row = RW'(i_in.read_row);
    assign rd_col = RW'(i_in.read_col);
    assign rd_outside = (SW'(i_in.read_row) >= h_side) || (SW'(i_in.read_col) >= w_side);
    assign draw_bad = i_in.rect_width[COORD_W-1] || (i_in.rect_width == '0)
                   || i_in.rect_height[COORD_W-1] || (i_in.rect_height == '0)
                   || ((i_in.shape_type != SHAPE_OUTLINE)
                       && (i_in.shape_type != SHAPE_FILLED));

    // Edge tests: dx and dy are the pixel position relative to the left and top edges.
    assign in_x = !r_dx[DIFF_W-1] && (r_dx <= r_rw);
    assign in_y = !r_dy[DIFF_W-1] && (r_dy <= r_rh);
    assign bd_x = (r_dx < ONE) || (r_dx > r_rw_m1);
    assign bd_y = (r_dy < ONE) || (r_dy > r_rh_m1);
    assign hit  = in_x && in_y && (!r_outline || bd_x || bd_y);

    assign last_col = (SW'(r_col) + SW'(1)) == w_side;
    assign last_row = (SW'(r_row) + SW'(1)) == h_side;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign ram_we      = (r_state == S_SCAN) && (r_clear || hit);
    assign ram_wdata   = r_clear ? r_bg : r_color;
    assign ram_addr    = (r_state == S_IDLE) ? {rd_row[IDX_W-1:0], rd_col[IDX_W-1:0]}
                                             : {r_row, r_col};

    rcr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_canvas (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_pixel  <= '0;
                        r_clear      <= (i_in.cmd == CMD_CLEAR);
                        r_outline    <= (i_in.shape_type == SHAPE_OUTLINE);
                        r_color      <= i_in.color;
                        r_dx         <= t_diff'(0) - t_diff'(i_in.rect_x);
                        r_dx0        <= t_diff'(0) - t_diff'(i_in.rect_x);
                        r_dy         <= t_diff'(0) - t_diff'(i_in.rect_y);
                        r_rw         <= t_diff'(i_in.rect_width);
                        r_rh         <= t_diff'(i_in.rect_height);
                        r_rw_m1      <= t_diff'(i_in.rect_width) - ONE;
                        r_rh_m1      <= t_diff'(i_in.rect_height) - ONE;
                        case (i_in.cmd)
                            CMD_CLEAR: begin
                                r_err        <= 1'b0;
                                r_res_status <= ST_OK;
                                r_state      <= S_SCAN;
                            end
                            CMD_DRAW: begin
                                if (r_err || draw_bad) begin
                                    r_err        <= 1'b1;
                                    r_res_status <= ST_ERROR;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_SCAN;
                                end
                            end
                            CMD_READ: begin
                                if (rd_outside) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_READ;
                                end
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (last_col) begin
                        r_col <= '0;
                        r_dx  <= r_dx0;
                        if (last_row) begin
                            r_row   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_row <= r_row + IDX_W'(1);
                            r_dy  <= r_dy + ONE;
                        end
                    end else begin
                        r_col <= r_col + IDX_W'(1);
                        r_dx  <= r_dx + ONE;
                    end
                end
                S_READ: begin
                    r_res_pixel <= ram_rdata;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_pixel  <= r_res_pixel;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.pixel  = r_out_pixel;

    a_scan_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((SW'(r_col) < w_side) && (SW'(r_row) < h_side)))
        else $error("Scan position outside the active canvas.");

    a_idle_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_row == '0) && (r_col == '0)))
        else $error("Scan position not at the origin between commands.");

    a_write_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_SCAN) && !(r_err && !r_clear)))
        else $error("Canvas written outside a permitted scan.");

    a_clear_drops_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_clear) |-> !r_err)
        else $error("Error flag set during a clear.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_status)
                                           && $stable(r_out_pixel)))
        else $error("Pending result lost before its transfer.");

endmodule
`default_nettype wire
